// ===== design/mlfd_pkg.sv =====
// ----------------------------------------------------------------------------
// mlfd_pkg
// Shared types and constants of the length-prefixed frame deframer.
// ----------------------------------------------------------------------------
package mlfd_pkg;

	localparam int HeaderBytes = 8;
	localparam int LengthBits  = 32;
	localparam int CountBits   = $clog2(HeaderBytes);

	localparam logic [7:0] MagicFirst  = 8'h56;
	localparam logic [7:0] MagicSecond = 8'h5A;

	localparam logic [CountBits-1:0] CntMagic0 = CountBits'(0);
	localparam logic [CountBits-1:0] CntMagic1 = CountBits'(1);
	localparam logic [CountBits-1:0] CntFlag0  = CountBits'(2);
	localparam logic [CountBits-1:0] CntFlag1  = CountBits'(3);
	localparam logic [CountBits-1:0] CntLast   = CountBits'(HeaderBytes - 1);

	typedef struct packed {
		logic        format_error;
		logic        empty_packet;
		logic        last_of_packet;
		logic [15:0] packet_flag;
		logic [7:0]  payload_byte;
	} res_t;

endpackage

// ===== design/mlfd_parser.sv =====
// ----------------------------------------------------------------------------
// mlfd_parser
// Input byte register and header/payload state tracking.
// ----------------------------------------------------------------------------
module mlfd_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_byte,
	output logic              res_valid,
	input  logic              res_ready,
	output mlfd_pkg::res_t    res
);

	logic                                byte_valid_s1;
	logic [7:0]                          byte_s1;
	logic [mlfd_pkg::CountBits-1:0]      hdr_cnt_q;
	logic                                magic_ok_q;
	logic [15:0]                         flag_q;
	logic [mlfd_pkg::LengthBits-1:0]     rem_len_q;
	logic                                in_payload_q;
	logic                                halted_q;

	logic                                advance;
	logic [mlfd_pkg::LengthBits-1:0]     len_shift;
	logic [mlfd_pkg::LengthBits-1:0]     len_dec;
	logic                                hdr_done;

	assign advance   = byte_valid_s1 && res_ready;
	assign in_ready  = !byte_valid_s1 || res_ready;
	assign len_shift = (rem_len_q << 8) | mlfd_pkg::LengthBits'(byte_s1);
	assign len_dec   = rem_len_q - mlfd_pkg::LengthBits'(1);
	assign hdr_done  = !halted_q && !in_payload_q && (hdr_cnt_q == mlfd_pkg::CntLast);

	always_comb begin
		res       = '0;
		res_valid = 1'b0;
		if (byte_valid_s1 && !halted_q) begin
			if (in_payload_q) begin
				res_valid          = 1'b1;
				res.payload_byte   = byte_s1;
				res.packet_flag    = flag_q;
				res.last_of_packet = (rem_len_q == mlfd_pkg::LengthBits'(1));
			end else if (hdr_done) begin
				if (!magic_ok_q) begin
					res_valid        = 1'b1;
					res.format_error = 1'b1;
				end else if (len_shift == '0) begin
					res_valid        = 1'b1;
					res.empty_packet = 1'b1;
					res.packet_flag  = flag_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			byte_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_cnt_q    <= '0;
			magic_ok_q   <= 1'b1;
			flag_q       <= '0;
			rem_len_q    <= '0;
			in_payload_q <= 1'b0;
			halted_q     <= 1'b0;
		end else if (advance && !halted_q) begin
			if (in_payload_q) begin
				rem_len_q <= len_dec;
				if (len_dec == '0) begin
					in_payload_q <= 1'b0;
					hdr_cnt_q    <= '0;
					magic_ok_q   <= 1'b1;
				end
			end else begin
				case (hdr_cnt_q)
					mlfd_pkg::CntMagic0: begin
						magic_ok_q <= (byte_s1 == mlfd_pkg::MagicFirst);
					end
					mlfd_pkg::CntMagic1: begin
						magic_ok_q <= magic_ok_q && (byte_s1 == mlfd_pkg::MagicSecond);
					end
					mlfd_pkg::CntFlag0, mlfd_pkg::CntFlag1: begin
						flag_q <= {flag_q[7:0], byte_s1};
					end
					default: begin
						rem_len_q <= len_shift;
					end
				endcase
				if (hdr_done) begin
					hdr_cnt_q <= '0;
					if (!magic_ok_q) begin
						halted_q <= 1'b1;
					end else if (len_shift != '0) begin
						in_payload_q <= 1'b1;
					end
				end else begin
					hdr_cnt_q <= hdr_cnt_q + mlfd_pkg::CountBits'(1);
				end
			end
		end
	end

endmodule

// ===== design/mlfd_out_stage.sv =====
// ----------------------------------------------------------------------------
// mlfd_out_stage
// Result register with a skid entry, so that upstream ready is registered.
// ----------------------------------------------------------------------------
module mlfd_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  mlfd_pkg::res_t    in_res,
	output logic              out_valid,
	input  logic              out_ready,
	output mlfd_pkg::res_t    out_res
);

	logic              out_valid_q;
	logic              skid_valid_q;
	mlfd_pkg::res_t    out_res_q;
	mlfd_pkg::res_t    skid_res_q;

	assign in_ready  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_ready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_valid;
			end
		end else if (in_valid && !skid_valid_q) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_res_q <= skid_res_q;
			end else if (in_valid) begin
				out_res_q <= in_res;
			end
		end else if (in_valid && !skid_valid_q) begin
			skid_res_q <= in_res;
		end
	end

endmodule

// ===== design/magic_length_frame_deframer_top.sv =====
// ----------------------------------------------------------------------------
// magic_length_frame_deframer_top
// Splits a received byte stream into frames with an eight-byte header ('V',
// 'Z', 16-bit big-endian flag, 32-bit big-endian length) followed by payload.
// The block takes one byte per cycle while the result stage can take its beat;
// output back-pressure holds the input. A byte is held in the input register,
// where a short counter and compare update of the frame state decides its
// result. The result register, with its skid entry, then presents the beat.
// Payload bytes come out with the frame's flag and tlast on the final byte; a
// zero-length frame gives one empty beat and a bad magic gives one error beat,
// after which every byte is accepted and dropped until reset. Header bytes
// other than the eighth give no beat.
// ----------------------------------------------------------------------------
module magic_length_frame_deframer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [7:0] payload_byte, [23:8] packet_flag
	output logic        m_axis_tlast,  // last_of_packet
	output logic [1:0]  m_axis_tuser   // [0] empty_packet, [1] format_error
);

	logic              res_valid;
	logic              res_ready;
	mlfd_pkg::res_t    res;
	mlfd_pkg::res_t    out_res;

	mlfd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_byte   (s_axis_tdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	mlfd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (res_valid),
		.in_ready  (res_ready),
		.in_res    (res),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	assign m_axis_tdata = {out_res.packet_flag, out_res.payload_byte};
	assign m_axis_tlast = out_res.last_of_packet;
	assign m_axis_tuser = {out_res.format_error, out_res.empty_packet};

endmodule

// ===== design/mlfd_checker.sv =====
// ----------------------------------------------------------------------------
// mlfd_checker
// Port-level checks on the deframer's result stream.
// ----------------------------------------------------------------------------
module mlfd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic        m_axis_tlast,
	input logic [1:0]  m_axis_tuser
);

	a_kind_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
		else $error("empty and error marked on the same beat");

	a_error_beat_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata == 24'h0 && !m_axis_tlast))
		else $error("error beat carries data or last");

	a_empty_beat_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[7:0] == 8'h0 && !m_axis_tlast))
		else $error("empty beat carries a payload byte or last");

	a_silent_after_error: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && m_axis_tuser[1]) |=> !m_axis_tvalid)
		else $error("beat delivered after a format error");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
			(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
		else $error("stalled output beat changed");

endmodule

bind magic_length_frame_deframer_top mlfd_checker u_mlfd_checker (.*);

// ===== test/tb_magic_length_frame_deframer_top.sv =====
// ----------------------------------------------------------------------------
// tb_magic_length_frame_deframer_top
// Self-checking bench for the frame deframer. Streams of 'V','Z' framed
// packets with random flags, lengths and payloads go in. Each accepted byte is
// run through a behavioural model of the deframer. Every output beat is
// checked against the oldest predicted beat. The run covers empty and long
// frames, a receiver hold-off that backs up the input, and a bad magic that
// halts the block.
// ----------------------------------------------------------------------------
module tb_magic_length_frame_deframer_top;

	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic [1:0]  m_axis_tuser;

	magic_length_frame_deframer_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #5 clk = ~clk;

	// Deframer state as the model sees it.
	logic [mlfd_pkg::CountBits-1:0]  hdr_count = mlfd_pkg::CntMagic0;
	logic                            magic_good = 1'b1;
	logic [15:0]                     cur_flag = 16'h0000;
	logic [mlfd_pkg::LengthBits-1:0] bytes_due = '0;
	logic                            in_payload = 1'b0;
	logic                            halted = 1'b0;

	mlfd_pkg::res_t expected_beats[$];

	int error_count = 0;
	int bytes_sent = 0;
	int frames_sent = 0;
	int beats_checked = 0;

	int gap_max = 0;
	int burst_left = 0;
	int stall_pct = 0;
	int hold_request = 0;
	int hold_left = 0;

	function automatic bit deframe_byte(input logic [7:0] b, output mlfd_pkg::res_t r);
		r = '0;
		if (halted)
			return 1'b0;
		if (in_payload) begin
			r.payload_byte = b;
			r.packet_flag = cur_flag;
			r.last_of_packet = (bytes_due == mlfd_pkg::LengthBits'(1));
			bytes_due = bytes_due - mlfd_pkg::LengthBits'(1);
			if (bytes_due == '0) begin
				in_payload = 1'b0;
				hdr_count = mlfd_pkg::CntMagic0;
				magic_good = 1'b1;
			end
			return 1'b1;
		end
		case (hdr_count)
			mlfd_pkg::CntMagic0: magic_good = (b == mlfd_pkg::MagicFirst);
			mlfd_pkg::CntMagic1: magic_good = magic_good && (b == mlfd_pkg::MagicSecond);
			mlfd_pkg::CntFlag0, mlfd_pkg::CntFlag1: cur_flag = {cur_flag[7:0], b};
			default: bytes_due = mlfd_pkg::LengthBits'({bytes_due, b});
		endcase
		if (hdr_count != mlfd_pkg::CntLast) begin
			hdr_count = hdr_count + mlfd_pkg::CountBits'(1);
			return 1'b0;
		end
		hdr_count = mlfd_pkg::CntMagic0;
		if (!magic_good) begin
			halted = 1'b1;
			r.format_error = 1'b1;
			return 1'b1;
		end
		if (bytes_due == '0) begin
			r.empty_packet = 1'b1;
			r.packet_flag = cur_flag;
			return 1'b1;
		end
		in_payload = 1'b1;
		return 1'b0;
	endfunction

	task automatic send_byte(input logic [7:0] b);
		mlfd_pkg::res_t r;
		int gap;
		s_axis_tdata <= b;
		s_axis_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_axis_tready);
		bytes_sent++;
		if (deframe_byte(b, r))
			expected_beats.push_back(r);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	task automatic send_header(input logic [7:0] m0, input logic [7:0] m1,
			input logic [15:0] flag, input logic [31:0] len);
		send_byte(m0);
		send_byte(m1);
		send_byte(flag[15:8]);
		send_byte(flag[7:0]);
		send_byte(len[31:24]);
		send_byte(len[23:16]);
		send_byte(len[15:8]);
		send_byte(len[7:0]);
		frames_sent++;
	endtask

	task automatic send_frame(input logic [15:0] flag, input logic [31:0] len);
		send_header(mlfd_pkg::MagicFirst, mlfd_pkg::MagicSecond, flag, len);
		for (int unsigned i = 0; i < len; i++)
			send_byte(8'($urandom_range(0, 255)));
	endtask

	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (hold_request > 0) begin
			hold_left = hold_request - 1;
			hold_request = 0;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		mlfd_pkg::res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			beats_checked++;
			if (expected_beats.size() == 0) begin
				$error("Unexpected output beat: tdata=%h tlast=%b tuser=%b",
					m_axis_tdata, m_axis_tlast, m_axis_tuser);
				error_count++;
			end else begin
				want = expected_beats[0];
				expected_beats.delete(0);
				if (m_axis_tdata[7:0] !== want.payload_byte) begin
					$error("payload_byte: expected %h, got %h", want.payload_byte,
						m_axis_tdata[7:0]);
					error_count++;
				end
				if (m_axis_tdata[23:8] !== want.packet_flag) begin
					$error("packet_flag: expected %h, got %h", want.packet_flag,
						m_axis_tdata[23:8]);
					error_count++;
				end
				if (m_axis_tlast !== want.last_of_packet) begin
					$error("last_of_packet: expected %b, got %b", want.last_of_packet,
						m_axis_tlast);
					error_count++;
				end
				if (m_axis_tuser[0] !== want.empty_packet) begin
					$error("empty_packet: expected %b, got %b", want.empty_packet,
						m_axis_tuser[0]);
					error_count++;
				end
				if (m_axis_tuser[1] !== want.format_error) begin
					$error("format_error: expected %b, got %b", want.format_error,
						m_axis_tuser[1]);
					error_count++;
				end
			end
		end
	end

	task automatic test_directed_frames();
		gap_max = 0;
		stall_pct = 0;
		send_header(mlfd_pkg::MagicFirst, mlfd_pkg::MagicSecond, 16'h0000, 32'h0000_0000);
		send_header(mlfd_pkg::MagicFirst, mlfd_pkg::MagicSecond, 16'hFFFF, 32'h0000_0000);
		send_header(mlfd_pkg::MagicFirst, mlfd_pkg::MagicSecond, 16'h8001, 32'h0000_0002);
		send_byte(8'h00);
		send_byte(8'hFF);
	endtask

	task automatic test_long_frame();
		gap_max = 0;
		stall_pct = 0;
		send_frame(16'($urandom), 32'h0000_0120);
	endtask

	task automatic test_backpressure();
		gap_max = 0;
		stall_pct = 0;
		hold_request = 300;
		send_frame(16'($urandom), 32'd150);
		send_frame(16'($urandom), 32'd0);
	endtask

	task automatic test_random_frames();
		int gap_sel[6] = '{0, 3, 0, 8, 2, 0};
		int stall_sel[6] = '{0, 25, 50, 10, 70, 0};
		int seg_start;
		int sel;
		logic [31:0] len;
		for (int seg = 0; seg < 6; seg++) begin
			gap_max = gap_sel[seg];
			stall_pct = stall_sel[seg];
			seg_start = bytes_sent;
			while (bytes_sent - seg_start < 170) begin
				sel = $urandom_range(0, 99);
				if (sel < 20)
					len = 0;
				else if (sel < 70)
					len = $urandom_range(1, 8);
				else if (sel < 95)
					len = $urandom_range(9, 40);
				else
					len = $urandom_range(41, 200);
				send_frame(16'($urandom), len);
			end
		end
	endtask

	task automatic test_bad_magic();
		gap_max = 2;
		stall_pct = 20;
		send_header(mlfd_pkg::MagicFirst, mlfd_pkg::MagicSecond ^ 8'h20, 16'hFFFF,
			32'hFFFF_FFFF);
		repeat (20) send_byte(8'($urandom_range(0, 255)));
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_frames();
		test_long_frame();
		test_backpressure();
		test_random_frames();
		test_bad_magic();
		s_axis_tvalid <= 1'b0;
		stall_pct = 0;
		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		$display("Sent %0d bytes in %0d frames and checked %0d output beats.",
			bytes_sent, frames_sent, beats_checked);
		$display("Covered empty, short, long and back-pressured frames, then a bad magic.");
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
